// ===== src/cdw_pkg.sv =====
// Shared constants, types and helpers for the card draw block.
package cdw_pkg;

    localparam int DECK_SIZE      = 52;
    localparam int STORE_DEPTH    = 52;
    localparam int CARDS_PER_HAND = 13;

    localparam int CARD_W = 6;                        // card identifier
    localparam int CNT_W  = 6;                        // remaining count
    localparam int ADDR_W = $clog2(STORE_DEPTH);      // deck position
    localparam int RND_W  = 32;                       // random word
    localparam int DIV_STEPS = RND_W;                 // one quotient bit per cycle
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Input action codes carried on s_tuser.
    localparam logic ACT_RELOAD = 1'b0;
    localparam logic ACT_DRAW   = 1'b1;

    // Deck store control from the sequencer.
    typedef struct packed {
        logic              clr;       // reload: deck back to ascending order
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [CARD_W-1:0] wr_data;
    } deck_ctrl_t;

    // Value split into groups of 13.
    typedef struct packed {
        logic [1:0] quo;
        logic [3:0] rmd;
    } split13_t;

    function automatic split13_t split13(input logic [5:0] v);
        split13_t   s;
        logic [5:0] base;
        begin
            if (v >= 6'(3 * CARDS_PER_HAND))
            begin
                s.quo = 2'd3;
                base  = 6'(3 * CARDS_PER_HAND);
            end
            else if (v >= 6'(2 * CARDS_PER_HAND))
            begin
                s.quo = 2'd2;
                base  = 6'(2 * CARDS_PER_HAND);
            end
            else if (v >= 6'(CARDS_PER_HAND))
            begin
                s.quo = 2'd1;
                base  = 6'(CARDS_PER_HAND);
            end
            else
            begin
                s.quo = 2'd0;
                base  = 6'd0;
            end
            s.rmd = 4'(v - base);
            return s;
        end
    endfunction

endpackage

// ===== src/cdw_divider.sv =====
// Restoring remainder unit: 32-bit word modulo a 6-bit count, one bit per cycle.
module cdw_divider
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [cdw_pkg::RND_W-1:0]  dividend,
    input  logic [cdw_pkg::CNT_W-1:0]  divisor,
    output logic                       done,
    output logic [cdw_pkg::CNT_W-1:0]  remainder
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [cdw_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [cdw_pkg::RND_W-1:0]   word_reg, word_next;
    logic [cdw_pkg::CNT_W-1:0]   rem_reg, rem_next;
    logic [cdw_pkg::CNT_W-1:0]   div_reg, div_next;
    logic [cdw_pkg::CNT_W:0]     trial;

    // shift in the next dividend bit; trial stays below 2*divisor
    assign trial = {rem_reg, word_reg[cdw_pkg::RND_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        word_next = word_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            word_next = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            word_next = {word_reg[cdw_pkg::RND_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
                rem_next = cdw_pkg::CNT_W'(trial - {1'b0, div_reg});
            else
                rem_next = cdw_pkg::CNT_W'(trial);
            step_next = step_reg + 1'b1;
            if (step_reg == cdw_pkg::STEP_W'(cdw_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== src/cdw_deck.sv =====
// Deck store: 52 x 6 memory, one read and one write port, valid bit per entry.
module cdw_deck
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  cdw_pkg::deck_ctrl_t         ctrl,
    output logic [cdw_pkg::CARD_W-1:0]  rd_data
);

    logic [cdw_pkg::CARD_W-1:0]      mem [cdw_pkg::STORE_DEPTH];
    logic [cdw_pkg::STORE_DEPTH-1:0] vld_reg;
    logic [cdw_pkg::CARD_W-1:0]      rd_data_reg;
    logic                            rd_vld_reg;
    logic [cdw_pkg::ADDR_W-1:0]      rd_addr_reg;
    logic [cdw_pkg::CARD_W-1:0]      fresh;

    // an entry never written since reload holds its own position
    assign fresh   = (rd_addr_reg < cdw_pkg::ADDR_W'(cdw_pkg::DECK_SIZE)) ?
                     cdw_pkg::CARD_W'(rd_addr_reg) : '0;
    assign rd_data = rd_vld_reg ? rd_data_reg : fresh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (ctrl.clr)
            vld_reg <= '0;
        else if (ctrl.wr_en)
            vld_reg[ctrl.wr_addr] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
            mem[ctrl.wr_addr] <= ctrl.wr_data;
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[ctrl.rd_addr];
            rd_vld_reg  <= vld_reg[ctrl.rd_addr];
            rd_addr_reg <= ctrl.rd_addr;
        end
    end

endmodule

// ===== src/card_draw_without_replacement.sv =====
// Top level: card draw without replacement, sequencer, result register.
//
//  channel  | dir | handshake         | content
//  ---------+-----+-------------------+--------------------------------------
//  s_*      | in  | s_tvalid/s_tready | tuser action, tdata random_word
//  m_*      | out | m_tvalid/m_tready | tuser card_valid, tdata card fields
//
// Reload, or draw on an empty deck: from accept the result goes through
// S_OUT into the output register. Draw: S_DIV waits out the 32 steps of the
// bit-serial remainder unit and its done flag, S_CAPTURE reads the card,
// then S_SHIFT closes up the deck above it, one entry per cycle through the
// single-read/single-write deck store, S_RESULT stages the result and S_OUT
// loads the output register and hands off the beat.
// Reset clears the per-entry valid bits at once; no clearing pass.
// s_tready is high only while idle; a result beat waiting on m_tready holds
// the next item's result in the sequencer until the output register frees.
module card_draw_without_replacement
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] random_word
    input  logic        s_tuser,    // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [5:0] card_id, [7:6] suit, [11:8] rank,
                                    // [13:12] hand_number, [17:14] slot_in_hand,
                                    // [23:18] cards_left
    output logic        m_tuser     // [0] card_valid
);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_DIV,
        S_CAPTURE,
        S_SHIFT,
        S_RESULT,
        S_OUT
    } state_t;

    state_t                      state_reg, state_next;
    logic [cdw_pkg::CNT_W-1:0]   rem_reg, rem_next;       // cards in deck
    logic [cdw_pkg::ADDR_W-1:0]  idx_reg, idx_next;       // close-up position
    logic [cdw_pkg::CARD_W-1:0]  id_reg, id_next;         // drawn card
    logic [23:0]                 res_reg, res_next;       // staged result
    logic                        res_vld_reg, res_vld_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [23:0]                 m_tdata_reg, m_tdata_next;
    logic                        m_tuser_reg, m_tuser_next;

    logic                        accept;
    logic                        out_free;
    logic                        div_start;
    logic                        div_done;
    logic [cdw_pkg::CNT_W-1:0]   div_rem;
    cdw_pkg::deck_ctrl_t         deck_ctrl;
    logic [cdw_pkg::CARD_W-1:0]  deck_rd_data;
    logic [cdw_pkg::ADDR_W:0]    idx_plus1, idx_plus2;
    logic [cdw_pkg::CNT_W-1:0]   drawn;
    cdw_pkg::split13_t           card_split, pos_split;

    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign idx_plus1 = {1'b0, idx_reg} + 1'b1;
    assign idx_plus2 = {1'b0, idx_reg} + 2'd2;
    // cards dealt since reload = position of this card in the deal
    assign drawn      = cdw_pkg::CNT_W'(cdw_pkg::DECK_SIZE) - rem_reg;
    assign card_split = cdw_pkg::split13(id_reg);
    assign pos_split  = cdw_pkg::split13(drawn);
    assign div_start  = accept && (s_tuser != cdw_pkg::ACT_RELOAD) && (rem_reg != '0);

    cdw_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (s_tdata),
        .divisor   (rem_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    cdw_deck u_deck
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (deck_ctrl),
        .rd_data (deck_rd_data)
    );

    always_comb
    begin
        state_next    = state_reg;
        rem_next      = rem_reg;
        idx_next      = idx_reg;
        id_next       = id_reg;
        res_next      = res_reg;
        res_vld_next  = res_vld_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        deck_ctrl     = '0;

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == cdw_pkg::ACT_RELOAD)
                    begin
                        deck_ctrl.clr = 1'b1;
                        rem_next      = cdw_pkg::CNT_W'(cdw_pkg::DECK_SIZE);
                        res_vld_next  = 1'b0;
                        res_next      = {cdw_pkg::CNT_W'(cdw_pkg::DECK_SIZE), 18'd0};
                        state_next    = S_OUT;
                    end
                    else if (rem_reg == '0)
                    begin
                        // empty deck: nothing changes, invalid result
                        res_vld_next = 1'b0;
                        res_next     = '0;
                        state_next   = S_OUT;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    idx_next          = cdw_pkg::ADDR_W'(div_rem);
                    deck_ctrl.rd_en   = 1'b1;
                    deck_ctrl.rd_addr = cdw_pkg::ADDR_W'(div_rem);
                    state_next        = S_CAPTURE;
                end
            end
            S_CAPTURE:
            begin
                id_next = deck_rd_data;
                if (idx_plus1 < (cdw_pkg::ADDR_W+1)'(rem_reg))
                begin
                    deck_ctrl.rd_en   = 1'b1;
                    deck_ctrl.rd_addr = cdw_pkg::ADDR_W'(idx_plus1);
                    state_next        = S_SHIFT;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_SHIFT:
            begin
                // move entry idx+1 down to idx, fetch the one after
                deck_ctrl.wr_en   = 1'b1;
                deck_ctrl.wr_addr = idx_reg;
                deck_ctrl.wr_data = deck_rd_data;
                idx_next          = cdw_pkg::ADDR_W'(idx_plus1);
                if (idx_plus2 < (cdw_pkg::ADDR_W+1)'(rem_reg))
                begin
                    deck_ctrl.rd_en   = 1'b1;
                    deck_ctrl.rd_addr = cdw_pkg::ADDR_W'(idx_plus2);
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                rem_next     = rem_reg - 1'b1;
                res_vld_next = 1'b1;
                res_next     = {rem_reg - 1'b1, pos_split.rmd, pos_split.quo,
                                card_split.rmd + 4'd1, card_split.quo, id_reg};
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_reg;
                    m_tuser_next  = res_vld_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            rem_reg      <= cdw_pkg::CNT_W'(cdw_pkg::DECK_SIZE);
            idx_reg      <= '0;
            id_reg       <= '0;
            res_reg      <= '0;
            res_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rem_reg      <= rem_next;
            idx_reg      <= idx_next;
            id_reg       <= id_next;
            res_reg      <= res_next;
            res_vld_reg  <= res_vld_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            m_tuser_reg  <= m_tuser_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= cdw_pkg::CNT_W'(cdw_pkg::DECK_SIZE))
        else $error("remaining count above deck size");

    a_shift_in_deck: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (idx_plus1 < (cdw_pkg::ADDR_W+1)'(rem_reg)))
        else $error("close-up write outside live deck");

    a_reload_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser == cdw_pkg::ACT_RELOAD)) |=>
        (rem_reg == cdw_pkg::CNT_W'(cdw_pkg::DECK_SIZE)))
        else $error("reload did not refill count");

    a_draw_left: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[23:18] < cdw_pkg::CNT_W'(cdw_pkg::DECK_SIZE)))
        else $error("drawn beat reports a full deck");

endmodule
